@@ src/pq2e_pkg.sv @@
`default_nettype none
package pq2e_pkg;

  // pipeline depths of the fixed parts
  localparam int MAT_LAT  = 4;
  localparam int SQ_STEPS = 32;
  localparam int SQRT_LAT = SQ_STEPS + 1;

  localparam int CORDIC_ITER_DEF = 24;

  localparam int POS_W = 32;
  localparam int MM_W  = 42;
  localparam int Q_W   = 32;
  localparam int ANG_W = 32;
  localparam int THR_W = 31;
  localparam int M_W   = 33;  // matrix entry after the 31 bit shift
  localparam int D_W   = 32;  // scaled norm
  localparam int S_W   = 32;  // sy root
  localparam int CIN_W = 34;  // CORDIC operand in
  localparam int CW    = 36;  // CORDIC x / y datapath
  localparam int ZW    = 34;  // CORDIC angle accumulator

  localparam logic [THR_W-1:0] THR_RESET = 31'd1074;
  localparam logic signed [ZW-1:0] PIH_FX = 34'sd421657428;

  // scaled rotation matrix and status, handed from the matrix front end
  typedef struct packed {
    logic signed [M_W-1:0] m00;
    logic signed [M_W-1:0] m10;
    logic signed [M_W-1:0] m20;
    logic signed [M_W-1:0] m11;
    logic signed [M_W-1:0] m12;
    logic signed [M_W-1:0] m21;
    logic signed [M_W-1:0] m22;
    logic [D_W-1:0]        dd;
    logic                  inval;
  } mat_t;

  // arctan(2^-i) in Q3.28, rounded to nearest
  function automatic logic signed [ZW-1:0] arc_fx(int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = 34'sd210828714;
      1:  r = 34'sd124459457;
      2:  r = 34'sd65760959;
      3:  r = 34'sd33381290;
      4:  r = 34'sd16755422;
      5:  r = 34'sd8385879;
      6:  r = 34'sd4193963;
      7:  r = 34'sd2097109;
      8:  r = 34'sd1048571;
      9:  r = 34'sd524287;
      10: r = 34'sd262144;
      11: r = 34'sd131072;
      12: r = 34'sd65536;
      13: r = 34'sd32768;
      14: r = 34'sd16384;
      15: r = 34'sd8192;
      16: r = 34'sd4096;
      17: r = 34'sd2048;
      18: r = 34'sd1024;
      19: r = 34'sd512;
      20: r = 34'sd256;
      21: r = 34'sd128;
      22: r = 34'sd64;
      23: r = 34'sd32;
      24: r = 34'sd16;
      25: r = 34'sd8;
      26: r = 34'sd4;
      27: r = 34'sd2;
      28: r = 34'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

@@ src/pq2e_in_if.sv @@
`default_nettype none
interface pq2e_in_if;
  import pq2e_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] pos_x_m;
  logic signed [POS_W-1:0] pos_y_m;
  logic signed [POS_W-1:0] pos_z_m;
  logic signed [Q_W-1:0]   quat_x;
  logic signed [Q_W-1:0]   quat_y;
  logic signed [Q_W-1:0]   quat_z;
  logic signed [Q_W-1:0]   quat_w;

  modport source (output valid, pos_x_m, pos_y_m, pos_z_m, quat_x, quat_y, quat_z, quat_w,
                  input ready);
  modport sink (input valid, pos_x_m, pos_y_m, pos_z_m, quat_x, quat_y, quat_z, quat_w,
                output ready);
endinterface
`default_nettype wire

@@ src/pq2e_out_if.sv @@
`default_nettype none
interface pq2e_out_if;
  import pq2e_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [MM_W-1:0]  pos_x_mm;
  logic signed [MM_W-1:0]  pos_y_mm;
  logic signed [MM_W-1:0]  pos_z_mm;
  logic signed [ANG_W-1:0] roll_rad;
  logic signed [ANG_W-1:0] pitch_rad;
  logic signed [ANG_W-1:0] yaw_rad;
  logic                    gimbal_lock;
  logic                    invalid_quat;

  modport source (output valid, pos_x_mm, pos_y_mm, pos_z_mm, roll_rad, pitch_rad, yaw_rad,
                  gimbal_lock, invalid_quat, input ready);
  modport sink (input valid, pos_x_mm, pos_y_mm, pos_z_mm, roll_rad, pitch_rad, yaw_rad,
                gimbal_lock, invalid_quat, output ready);
endinterface
`default_nettype wire

@@ src/pose_quaternion_to_euler_mm_top.sv @@
// Throughput: one item per cycle; the whole pipeline advances unless the output
// register holds a result that is not taken.
// Reset (rst_ni low, asynchronous): pipeline emptied, threshold back to 1074.
`default_nettype none
module pose_quaternion_to_euler_mm_top import pq2e_pkg::*; #(
  parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_we_i,
  input  wire logic [THR_W-1:0] cfg_wdata_i,
  pq2e_in_if.sink               in_i,
  pq2e_out_if.source            out_o
);

  localparam int LAT = MAT_LAT + SQRT_LAT + 2 + CORDIC_ITERATIONS + 1 + 1;

  logic             en;
  logic [THR_W-1:0] thr_q;
  logic [LAT-1:0]   vld_q;

  mat_t                     mat, mat_dly, mat_g1_q;
  logic [S_W-1:0]           s, s_g1_q;
  logic [THR_W+D_W-1:0]     prod_g1_q;
  logic                     gim;
  logic                     gim_g2_q, inval_g2_q;
  logic signed [CIN_W-1:0]  py_q, px_q, ry_q, rx_q, yy_q, yx_q;
  logic signed [ANG_W-1:0]  roll_z, pitch_z, yaw_z;
  logic [1:0]               flg_dly;
  logic [3*POS_W-1:0]       pos_dly;

  assign en         = !vld_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_i.valid};
    end
  end

  pq2e_matrix u_matrix (
    .clk_i (clk_i),
    .en_i  (en),
    .qx_i  (in_i.quat_x),
    .qy_i  (in_i.quat_y),
    .qz_i  (in_i.quat_z),
    .qw_i  (in_i.quat_w),
    .mat_o (mat)
  );

  pq2e_sqrt u_sqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .a_i   (mat.m21),
    .b_i   (mat.m22),
    .s_o   (s)
  );

  pq2e_delay #(.WIDTH($bits(mat_t)), .DEPTH(SQRT_LAT)) u_mat_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   (mat),
    .q_o   (mat_dly)
  );

  // threshold product
  always_ff @(posedge clk_i) begin
    if (en) begin
      mat_g1_q  <= mat_dly;
      s_g1_q    <= s;
      prod_g1_q <= thr_q * mat_dly.dd;
    end
  end

  // gimbal lock test and arctangent operand select
  assign gim = ({1'b0, s_g1_q, 30'b0} <= prod_g1_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      gim_g2_q   <= gim;
      inval_g2_q <= mat_g1_q.inval;
      py_q       <= -CIN_W'(mat_g1_q.m20);
      px_q       <= CIN_W'({1'b0, s_g1_q});
      ry_q       <= gim ? -CIN_W'(mat_g1_q.m12) : CIN_W'(mat_g1_q.m21);
      rx_q       <= gim ? CIN_W'(mat_g1_q.m11) : CIN_W'(mat_g1_q.m22);
      yy_q       <= CIN_W'(mat_g1_q.m10);
      yx_q       <= CIN_W'(mat_g1_q.m00);
    end
  end

  pq2e_cordic #(.ITER(CORDIC_ITERATIONS)) u_roll (
    .clk_i (clk_i), .en_i (en), .y_i (ry_q), .x_i (rx_q), .z_o (roll_z)
  );

  pq2e_cordic #(.ITER(CORDIC_ITERATIONS)) u_pitch (
    .clk_i (clk_i), .en_i (en), .y_i (py_q), .x_i (px_q), .z_o (pitch_z)
  );

  pq2e_cordic #(.ITER(CORDIC_ITERATIONS)) u_yaw (
    .clk_i (clk_i), .en_i (en), .y_i (yy_q), .x_i (yx_q), .z_o (yaw_z)
  );

  pq2e_delay #(.WIDTH(2), .DEPTH(CORDIC_ITERATIONS + 1)) u_flg_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({gim_g2_q, inval_g2_q}),
    .q_o   (flg_dly)
  );

  pq2e_delay #(.WIDTH(3 * POS_W), .DEPTH(LAT - 1)) u_pos_dly (
    .clk_i (clk_i),
    .en_i  (en),
    .d_i   ({in_i.pos_x_m, in_i.pos_y_m, in_i.pos_z_m}),
    .q_o   (pos_dly)
  );

  // output register: mm scaling and special cases
  always_ff @(posedge clk_i) begin
    if (en) begin
      out_o.pos_x_mm     <= MM_W'($signed(pos_dly[3*POS_W-1:2*POS_W])) * 42'sd1000;
      out_o.pos_y_mm     <= MM_W'($signed(pos_dly[2*POS_W-1:POS_W])) * 42'sd1000;
      out_o.pos_z_mm     <= MM_W'($signed(pos_dly[POS_W-1:0])) * 42'sd1000;
      out_o.roll_rad     <= flg_dly[0] ? '0 : roll_z;
      out_o.pitch_rad    <= flg_dly[0] ? '0 : pitch_z;
      out_o.yaw_rad      <= (flg_dly[0] || flg_dly[1]) ? '0 : yaw_z;
      out_o.gimbal_lock  <= flg_dly[1] && !flg_dly[0];
      out_o.invalid_quat <= flg_dly[0];
    end
  end

  assign out_o.valid = vld_q[LAT-1];

endmodule
`default_nettype wire

@@ src/pq2e_delay.sv @@
`default_nettype none
module pq2e_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic [WIDTH-1:0] d_i,
  output logic      [WIDTH-1:0] q_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  // shift line, advances with the pipeline
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_q[i] <= tap_q[i-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule
`default_nettype wire

@@ src/pq2e_matrix.sv @@
`default_nettype none
module pq2e_matrix import pq2e_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [Q_W-1:0] qx_i,
  input  wire logic signed [Q_W-1:0] qy_i,
  input  wire logic signed [Q_W-1:0] qz_i,
  input  wire logic signed [Q_W-1:0] qw_i,
  output mat_t                       mat_o
);

  function automatic logic [4:0] msb_pos(logic [28:0] v);
    logic [4:0] p;
    p = '0;
    for (int b = 0; b < 29; b++) begin
      if (v[b]) p = 5'(b);
    end
    return p;
  endfunction

  logic signed [Q_W-1:0] qin [4];
  logic [Q_W-1:0]        mag [4];
  logic                  rsh, zero;
  logic [Q_W-1:0]        mag_or;

  logic signed [Q_W-1:0] q1_q [4];
  logic [28:0]           or1_q;
  logic                  left1_q, inval1_q;

  logic signed [Q_W-1:0] q2_q [4];
  logic                  inval2_q;
  logic [4:0]            lsh;

  logic signed [63:0]    xx_q, yy_q, zz_q, ww_q, xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  logic                  inval3_q;

  logic signed [63:0]    a00, a11, a22, b10, b20, b12, b21;
  logic [63:0]           dsum;
  mat_t                  mat_q;

  assign qin[0] = qx_i;
  assign qin[1] = qy_i;
  assign qin[2] = qz_i;
  assign qin[3] = qw_i;

  // stage 1: magnitudes, one right shift if the largest is above 2^30
  always_comb begin
    rsh    = 1'b0;
    mag_or = '0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = qin[i][Q_W-1] ? Q_W'(-qin[i]) : Q_W'(qin[i]);
      if (mag[i] > 32'h4000_0000) rsh = 1'b1;
      mag_or = mag_or | mag[i];
    end
    zero = (mag_or == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        q1_q[i] <= rsh ? (qin[i] >>> 1) : qin[i];
      end
      or1_q    <= mag_or[28:0];
      left1_q  <= (mag_or[31:29] == '0);
      inval1_q <= zero;
    end
  end

  // stage 2: left shift until the largest magnitude reaches 2^29
  assign lsh = 5'd29 - msb_pos(or1_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 4; i++) begin
        q2_q[i] <= left1_q ? (q1_q[i] <<< lsh) : q1_q[i];
      end
      inval2_q <= inval1_q;
    end
  end

  // stage 3: component products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q <= q2_q[0] * q2_q[0];
      yy_q <= q2_q[1] * q2_q[1];
      zz_q <= q2_q[2] * q2_q[2];
      ww_q <= q2_q[3] * q2_q[3];
      xy_q <= q2_q[0] * q2_q[1];
      wz_q <= q2_q[3] * q2_q[2];
      xz_q <= q2_q[0] * q2_q[2];
      wy_q <= q2_q[3] * q2_q[1];
      yz_q <= q2_q[1] * q2_q[2];
      wx_q <= q2_q[3] * q2_q[0];
      inval3_q <= inval2_q;
    end
  end

  // stage 4: matrix entries and norm, floor shift by 31
  always_comb begin
    a00  = ww_q + xx_q - yy_q - zz_q;
    a11  = ww_q + yy_q - xx_q - zz_q;
    a22  = ww_q + zz_q - xx_q - yy_q;
    b10  = (xy_q + wz_q) <<< 1;
    b20  = (xz_q - wy_q) <<< 1;
    b12  = (yz_q - wx_q) <<< 1;
    b21  = (yz_q + wx_q) <<< 1;
    dsum = 64'(xx_q + yy_q + zz_q + ww_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mat_q.m00   <= a00[63:31];
      mat_q.m11   <= a11[63:31];
      mat_q.m22   <= a22[63:31];
      mat_q.m10   <= b10[63:31];
      mat_q.m20   <= b20[63:31];
      mat_q.m12   <= b12[63:31];
      mat_q.m21   <= b21[63:31];
      mat_q.dd    <= dsum[62:31];
      mat_q.inval <= inval3_q;
    end
  end

  assign mat_o = mat_q;

endmodule
`default_nettype wire

@@ src/pq2e_sqrt.sv @@
`default_nettype none
module pq2e_sqrt import pq2e_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire logic signed [M_W-1:0] a_i,
  input  wire logic signed [M_W-1:0] b_i,
  output logic [S_W-1:0]             s_o
);

  logic signed [2*M_W-1:0] sqa, sqb;
  logic [63:0] n_q [SQ_STEPS+1];
  logic [63:0] r_q [SQ_STEPS+1];

  // square and sum
  assign sqa = a_i * a_i;
  assign sqb = b_i * b_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0] <= sqa[63:0] + sqb[63:0];
      r_q[0] <= '0;
    end
  end

  // one root bit per stage, restoring form
  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * i);
    logic [63:0] t;
    logic        ge;
    assign t  = r_q[i] + BIT;
    assign ge = (n_q[i] >= t);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[i+1] <= ge ? (n_q[i] - t) : n_q[i];
        r_q[i+1] <= ge ? ((r_q[i] >> 1) + BIT) : (r_q[i] >> 1);
      end
    end
  end

  assign s_o = r_q[SQ_STEPS][S_W-1:0];

endmodule
`default_nettype wire

@@ src/pq2e_cordic.sv @@
`default_nettype none
module pq2e_cordic import pq2e_pkg::*; #(
  parameter int ITER = CORDIC_ITER_DEF
) (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic signed [CIN_W-1:0] y_i,
  input  wire logic signed [CIN_W-1:0] x_i,
  output logic signed [ANG_W-1:0]      z_o
);

  logic signed [CW-1:0] xe, ye, x0, y0;
  logic signed [ZW-1:0] z0;
  logic signed [CW-1:0] x_q [ITER+1];
  logic signed [CW-1:0] y_q [ITER+1];
  logic signed [ZW-1:0] z_q [ITER+1];

  // left half plane: turn by +-pi/2 first
  always_comb begin
    xe = CW'(x_i);
    ye = CW'(y_i);
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = PIH_FX;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -PIH_FX;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= x0;
      y_q[0] <= y0;
      z_q[0] <= z0;
    end
  end

  // vectoring iterations, one per stage; y at zero holds
  for (genvar i = 0; i < ITER; i++) begin : g_iter
    logic signed [CW-1:0] dx, dy;
    assign dx = x_q[i] >>> i;
    assign dy = y_q[i] >>> i;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + dy;
          y_q[i+1] <= y_q[i] - dx;
          z_q[i+1] <= z_q[i] + arc_fx(i);
        end else if (y_q[i] < 0) begin
          x_q[i+1] <= x_q[i] - dy;
          y_q[i+1] <= y_q[i] + dx;
          z_q[i+1] <= z_q[i] - arc_fx(i);
        end else begin
          x_q[i+1] <= x_q[i];
          y_q[i+1] <= y_q[i];
          z_q[i+1] <= z_q[i];
        end
      end
    end
  end

  assign z_o = z_q[ITER][ANG_W-1:0];

endmodule
`default_nettype wire

@@ dv/pq2e_tb_if.sv @@
`timescale 1ns / 100ps
`default_nettype none
// Interface instances used by the bench are the RTL's own; this file carries
// the bench-side transfer records shared by the stimulus and the checker.
package pq2e_tb_pkg;
  import pq2e_pkg::*;

  // one pose sample as driven on the input channel
  typedef struct {
    logic signed [POS_W-1:0] px, py, pz;
    logic signed [Q_W-1:0]   qx, qy, qz, qw;
  } pose_t;

  // one converted pose as seen on the output channel
  typedef struct {
    logic signed [MM_W-1:0]  mx, my, mz;
    logic signed [ANG_W-1:0] roll, pitch, yaw;
    logic                    lock, inval;
  } euler_t;
endpackage
`default_nettype wire

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import pq2e_pkg::*;
  import pq2e_tb_pkg::*;

  localparam int ITERS = CORDIC_ITER_DEF;
  localparam int LAT = 41 + ITERS;
  localparam int N_RAND = 1000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [THR_W-1:0] cfg_wdata_i = '0;

  pq2e_in_if  pose_ch ();
  pq2e_out_if euler_ch ();

  pose_quaternion_to_euler_mm_top #(.CORDIC_ITERATIONS(ITERS)) DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_i(pose_ch.sink), .out_o(euler_ch.source)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [THR_W-1:0] lock_thr = THR_RESET;
  euler_t pending_poses[$];
  int n_err = 0;
  int n_sent = 0;
  int n_got = 0;
  int n_lock = 0;
  int n_inval = 0;
  int rx_hold = 0;
  bit rx_stall_en = 1'b1;

  // floor shift of a signed value
  function automatic longint asr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint isqrt(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // CORDIC vectoring arctangent in Q3.28
  function automatic longint atan_q328(longint y, longint x);
    longint z = 0, t, dx, dy;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = PIH_FX;
      end else begin
        x = -y; y = t; z = -PIH_FX;
      end
    end
    for (int i = 0; i < ITERS && i < 32; i++) begin
      dx = asr(x, i);
      dy = asr(y, i);
      if (y > 0) begin
        x += dy; y -= dx; z += longint'(arc_fx(i));
      end else if (y < 0) begin
        x -= dy; y += dx; z -= longint'(arc_fx(i));
      end
    end
    return z;
  endfunction

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // expected conversion of one pose
  function automatic euler_t convert_pose(pose_t p);
    euler_t e;
    longint q[4], mx, x, y, z, w, xx, yy, zz, ww;
    longint m00, m10, m20, m11, m12, m21, m22, dd, s;
    e.mx = MM_W'(longint'(p.px) * 1000);
    e.my = MM_W'(longint'(p.py) * 1000);
    e.mz = MM_W'(longint'(p.pz) * 1000);
    e.roll = '0; e.pitch = '0; e.yaw = '0; e.lock = 1'b0; e.inval = 1'b0;
    q[0] = p.qx; q[1] = p.qy; q[2] = p.qz; q[3] = p.qw;
    mx = 0;
    foreach (q[i]) if (mag(q[i]) > mx) mx = mag(q[i]);
    if (mx == 0) begin
      e.inval = 1'b1;
      return e;
    end
    // normalize the largest magnitude into [2^29, 2^30]
    while (mx > (64'd1 << 30)) begin
      mx = 0;
      foreach (q[i]) begin
        q[i] = asr(q[i], 1);
        if (mag(q[i]) > mx) mx = mag(q[i]);
      end
    end
    while (mx < (64'd1 << 29)) begin
      mx = 0;
      foreach (q[i]) begin
        q[i] = q[i] * 2;
        if (mag(q[i]) > mx) mx = mag(q[i]);
      end
    end
    x = q[0]; y = q[1]; z = q[2]; w = q[3];
    xx = x * x; yy = y * y; zz = z * z; ww = w * w;
    m00 = asr(ww + xx - yy - zz, 31);
    m11 = asr(ww + yy - xx - zz, 31);
    m22 = asr(ww + zz - xx - yy, 31);
    m10 = asr(2 * (x * y + w * z), 31);
    m20 = asr(2 * (x * z - w * y), 31);
    m12 = asr(2 * (y * z - w * x), 31);
    m21 = asr(2 * (y * z + w * x), 31);
    dd = (xx + yy + zz + ww) >> 31;
    s = isqrt(longint'(m21 * m21 + m22 * m22));
    e.pitch = ANG_W'(atan_q328(-m20, s));
    if ((s << 30) <= longint'(lock_thr) * dd) begin
      e.lock = 1'b1;
      e.roll = ANG_W'(atan_q328(-m12, m11));
    end else begin
      e.roll = ANG_W'(atan_q328(m21, m22));
      e.yaw = ANG_W'(atan_q328(m10, m00));
    end
    return e;
  endfunction

  function automatic logic [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($signed($urandom_range(0, 2000)) - 1000);
      default: return $urandom;
    endcase
  endfunction

  // random quaternion: mostly unit-ish, some near gimbal lock, some noise
  function automatic pose_t rand_pose();
    pose_t p;
    int sel;
    p.px = rnd32(); p.py = rnd32(); p.pz = rnd32();
    sel = $urandom_range(0, 9);
    p.qx = $urandom; p.qy = $urandom; p.qz = $urandom; p.qw = $urandom;
    if (sel < 5) begin
      p.qx = p.qx >>> $urandom_range(1, 3); p.qy = p.qy >>> $urandom_range(1, 3);
      p.qz = p.qz >>> $urandom_range(1, 3); p.qw = p.qw >>> $urandom_range(1, 3);
    end else if (sel < 7) begin
      // w = y, x = +-z, with small jitter; pitch comes near 90 deg when x = -z
      p.qw = p.qy + 32'($signed($urandom_range(0, 8)) - 4);
      p.qx = ($urandom_range(0, 1) ? p.qz : -p.qz) + 32'($signed($urandom_range(0, 8)) - 4);
    end else if (sel == 7) begin
      p.qx = 32'($signed($urandom_range(0, 6)) - 3);
      p.qy = 32'($signed($urandom_range(0, 6)) - 3);
      p.qz = 32'($signed($urandom_range(0, 6)) - 3);
      p.qw = 32'($signed($urandom_range(0, 6)) - 3);
    end
    return p;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // drive one transfer, inputs change on the falling edge
  task automatic send_pose(pose_t p, bit use_gaps);
    int g;
    g = use_gaps ? ($urandom_range(0, 2) == 0 ? gap_len() : 0) : 0;
    if (g > 0) begin
      pose_ch.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    pose_ch.valid <= 1'b1;
    pose_ch.pos_x_m <= p.px; pose_ch.pos_y_m <= p.py; pose_ch.pos_z_m <= p.pz;
    pose_ch.quat_x <= p.qx; pose_ch.quat_y <= p.qy;
    pose_ch.quat_z <= p.qz; pose_ch.quat_w <= p.qw;
    do @(posedge clk_i); while (!pose_ch.ready);
    pending_poses.push_back(convert_pose(p));
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    pose_ch.valid <= 1'b0;
    while (pending_poses.size() != 0) @(negedge clk_i);
    repeat (LAT + 10) @(negedge clk_i);
  endtask

  task automatic write_thr(logic [THR_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    lock_thr = v;
  endtask

  // output side backpressure: stalls of random length, mostly short, a few long
  always @(negedge clk_i) begin
    if (!rx_stall_en) begin
      euler_ch.ready <= 1'b1;
      rx_hold = 0;
    end else if (rx_hold > 0) begin
      euler_ch.ready <= 1'b0;
      rx_hold--;
    end else if ($urandom_range(0, 3) == 0) begin
      euler_ch.ready <= 1'b0;
      rx_hold = gap_len();
    end else begin
      euler_ch.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    euler_t got, exp_e;
    if (rst_ni && euler_ch.valid && euler_ch.ready) begin
      got.mx = euler_ch.pos_x_mm; got.my = euler_ch.pos_y_mm; got.mz = euler_ch.pos_z_mm;
      got.roll = euler_ch.roll_rad; got.pitch = euler_ch.pitch_rad;
      got.yaw = euler_ch.yaw_rad; got.lock = euler_ch.gimbal_lock;
      got.inval = euler_ch.invalid_quat;
      n_got++;
      if (pending_poses.size() == 0) begin
        $error("result transfer with nothing expected");
        n_err++;
      end else begin
        exp_e = pending_poses.pop_front();
        n_lock += exp_e.lock;
        n_inval += exp_e.inval;
        if (got.mx !== exp_e.mx) begin
          $error("pos_x_mm exp %0d got %0d", exp_e.mx, got.mx); n_err++;
        end
        if (got.my !== exp_e.my) begin
          $error("pos_y_mm exp %0d got %0d", exp_e.my, got.my); n_err++;
        end
        if (got.mz !== exp_e.mz) begin
          $error("pos_z_mm exp %0d got %0d", exp_e.mz, got.mz); n_err++;
        end
        if (got.roll !== exp_e.roll) begin
          $error("roll_rad exp %0d got %0d", exp_e.roll, got.roll); n_err++;
        end
        if (got.pitch !== exp_e.pitch) begin
          $error("pitch_rad exp %0d got %0d", exp_e.pitch, got.pitch); n_err++;
        end
        if (got.yaw !== exp_e.yaw) begin
          $error("yaw_rad exp %0d got %0d", exp_e.yaw, got.yaw); n_err++;
        end
        if (got.lock !== exp_e.lock) begin
          $error("gimbal_lock exp %0b got %0b", exp_e.lock, got.lock); n_err++;
        end
        if (got.inval !== exp_e.inval) begin
          $error("invalid_quat exp %0b got %0b", exp_e.inval, got.inval); n_err++;
        end
      end
    end
  end

  // run limit
  initial begin
    #20ms;
    $display("TB_ERROR");
    $finish;
  end

  // directed table: positions and quaternions; expected typed only for the zero quaternion
  localparam int N_DIR = 14;
  logic [31:0] dir_tab[N_DIR][7] = '{
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0},
    '{32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h0, 32'h0, 32'h0, 32'h40000000},
    '{32'h80000000, 32'h7fffffff, 32'h1, 32'h40000000, 32'h0, 32'h0, 32'h0},
    '{32'h01000000, 32'h0, 32'h0, 32'h0, 32'h40000000, 32'h0, 32'h0},
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h40000000, 32'h0},
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h2d413ccd, 32'h0, 32'h2d413ccd},
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'hd2bec333, 32'h0, 32'h2d413ccd},
    '{32'h0, 32'h0, 32'h0, 32'h20000000, 32'h20000000, 32'h20000000, 32'h20000000},
    '{32'h0, 32'h0, 32'h0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000},
    '{32'h0, 32'h0, 32'h0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff},
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1},
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hffffffff},
    '{32'h5, 32'h5, 32'h5, 32'h0, 32'h0, 32'h40000000, 32'h0},
    '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'hc0000000}
  };

  initial begin
    pose_t p;
    euler_t e;
    pose_ch.valid = 1'b0;
    pose_ch.pos_x_m = '0; pose_ch.pos_y_m = '0; pose_ch.pos_z_m = '0;
    pose_ch.quat_x = '0; pose_ch.quat_y = '0; pose_ch.quat_z = '0; pose_ch.quat_w = '0;
    euler_ch.ready = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed rows at reset threshold
    for (int r = 0; r < N_DIR; r++) begin
      p.px = dir_tab[r][0]; p.py = dir_tab[r][1]; p.pz = dir_tab[r][2];
      p.qx = dir_tab[r][3]; p.qy = dir_tab[r][4]; p.qz = dir_tab[r][5]; p.qw = dir_tab[r][6];
      if (r == 0) begin
        e = convert_pose(p);
        if (!(e.inval && e.roll == 0 && e.pitch == 0 && e.yaw == 0 && !e.lock)) begin
          $error("zero quaternion row mispredicted");
          n_err++;
        end
      end
      send_pose(p, 1'b0);
    end
    drain();

    // random phases through several thresholds, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_thr(31'd0);
        1: write_thr(31'h7fffffff);
        2: write_thr(31'd1 << 30);
        3: write_thr(31'($urandom_range(0, 1 << 20)));
        default: write_thr(THR_RESET);
      endcase
      rx_stall_en = (ph != 2);
      for (int k = 0; k < N_RAND / 5; k++) begin
        // one hold-off until every result has come
        if (ph == 3 && k == 100) begin
          pose_ch.valid <= 1'b0;
          while (pending_poses.size() != 0) @(negedge clk_i);
        end
        send_pose(rand_pose(), ph != 2);
      end
      drain();
    end

    $display("sent %0d poses, checked %0d results (%0d gimbal lock, %0d invalid)",
             n_sent, n_got, n_lock, n_inval);
    $display("thresholds covered: zero, reset, max, 2^30 and a random value");
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
